[hdl/playfair_pair_cipher_top_assert.svh]
// Assertion macros for the Playfair pair cipher block.
`ifndef PLAYFAIR_PAIR_CIPHER_TOP_ASSERT_SVH
`define PLAYFAIR_PAIR_CIPHER_TOP_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PFC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pfc_pkg.sv]
package pfc_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5a;
    localparam logic [7:0] CHAR_UC_I = 8'h49;
    localparam logic [7:0] CHAR_UC_J = 8'h4a;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7a;
    localparam logic [4:0] IDX_J     = 5'd9;
    localparam logic [4:0] IDX_LAST  = 5'd25;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_KEY   = 2'd1,
        REQ_FINAL = 2'd2,
        REQ_TEXT  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIN,
        ST_POS,
        ST_CORNER,
        ST_OUT1,
        ST_OUT2
    } state_t;

    typedef struct packed {
        logic       we;
        logic [4:0] fill;     // square cell written
        logic [4:0] letter;   // letter index written
        logic [4:0] pos_ra0;
        logic [4:0] pos_ra1;
        logic [4:0] sq_ra0;
        logic [4:0] sq_ra1;
    } mem_req_t;

    typedef struct packed {
        logic [4:0] pos0;
        logic [4:0] pos1;
        logic [4:0] sq0;
        logic [4:0] sq1;
    } mem_rsp_t;

    typedef struct packed {
        logic       same_line;
        logic [4:0] addr0;
        logic [4:0] addr1;
    } geom_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= CHAR_LC_A && c <= CHAR_LC_Z) ? (c - 8'h20) : c;
        return (u == CHAR_UC_J) ? CHAR_UC_I : u;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHAR_UC_A) && (c <= CHAR_UC_Z);
    endfunction

    function automatic logic [4:0] letter_idx(input logic [7:0] c);
        return 5'(c - CHAR_UC_A);
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] pos);
        logic [2:0] r;
        if (pos >= 5'd20)      r = 3'd4;
        else if (pos >= 5'd15) r = 3'd3;
        else if (pos >= 5'd10) r = 3'd2;
        else if (pos >= 5'd5)  r = 3'd1;
        else                   r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] pos);
        return 3'(pos - 5'(pos_row(pos)) * 5'(SIDE));
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return 5'(row) * 5'(SIDE) + 5'(col);
    endfunction

endpackage

[hdl/pfc_keymem.sv]
module pfc_keymem (
    input  logic              aclk,
    input  pfc_pkg::mem_req_t req,
    output pfc_pkg::mem_rsp_t rsp
);

    // square: cell -> letter; position table: letter -> cell
    logic [4:0] square_mem [pfc_pkg::CELLS];
    logic [4:0] pos_mem    [pfc_pkg::LETTERS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            square_mem[req.fill] <= req.letter;
            pos_mem[req.letter]  <= req.fill;
        end
    end

    always_ff @(posedge aclk) begin
        rsp.pos0 <= pos_mem[req.pos_ra0];
        rsp.pos1 <= pos_mem[req.pos_ra1];
        rsp.sq0  <= square_mem[req.sq_ra0];
        rsp.sq1  <= square_mem[req.sq_ra1];
    end

endmodule

[hdl/pfc_pair_geom.sv]
module pfc_pair_geom (
    input  logic [4:0]     pos_a,
    input  logic [4:0]     pos_b,
    output pfc_pkg::geom_t geom
);

    logic [2:0] ra, ca, rb, cb;

    always_comb begin
        ra = pfc_pkg::pos_row(pos_a);
        ca = pfc_pkg::pos_col(pos_a);
        rb = pfc_pkg::pos_row(pos_b);
        cb = pfc_pkg::pos_col(pos_b);
        geom.same_line = (ra == rb) || (ca == cb);
        // opposite corners, each letter keeps its own row
        geom.addr0 = pfc_pkg::cell_addr(ra, cb);
        geom.addr1 = pfc_pkg::cell_addr(rb, ca);
    end

endmodule

[hdl/playfair_pair_cipher_top.sv]
// Playfair pair cipher: one transaction in flight at a time.
// Key character and clear complete on accept. Finalize walks the 26 letters, writing each
// unused one but J to the next cell. Text pair: straight to output when passed through, via
// ST_POS for a row/column swap, via ST_POS and ST_CORNER for a rectangle (position table read,
// then square read); the next transaction is taken once both results are delivered.
// Reset clears control state, fill count, used map and pending pair; memories are not cleared.
`include "playfair_pair_cipher_top_assert.svh"

module playfair_pair_cipher_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] req_type
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last
);

    pfc_pkg::state_t   state_reg, state_next;
    logic [4:0]        fill_reg, fill_next;
    logic [25:0]       used_reg, used_next;
    logic              sealed_reg, sealed_next;
    logic [7:0]        pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        a_reg, a_next;
    logic [7:0]        b_reg, b_next;
    logic [7:0]        o1_reg, o1_next;
    logic [7:0]        o2_reg, o2_next;
    logic [4:0]        k_reg, k_next;
    logic              blank0_reg, blank0_next;
    logic              blank1_reg, blank1_next;

    pfc_pkg::req_t     req;
    pfc_pkg::mem_req_t mreq;
    pfc_pkg::mem_rsp_t mrsp;
    pfc_pkg::geom_t    geom;
    logic              accept;
    logic [7:0]        c_fold;
    logic [4:0]        cur_idx, pend_idx;
    logic              key_ok, fin_ok, pair_in_square;

    pfc_keymem u_keymem (
        .aclk (aclk),
        .req  (mreq),
        .rsp  (mrsp)
    );

    pfc_pair_geom u_geom (
        .pos_a (mrsp.pos0),
        .pos_b (mrsp.pos1),
        .geom  (geom)
    );

    assign req      = pfc_pkg::req_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign c_fold   = pfc_pkg::fold_char(s_tdata);
    assign cur_idx  = pfc_pkg::letter_idx(c_fold);
    assign pend_idx = pfc_pkg::letter_idx(pend_reg);

    always_comb begin
        key_ok = (req == pfc_pkg::REQ_KEY) && !sealed_reg && pfc_pkg::is_upper(c_fold)
                 && !used_reg[cur_idx] && (fill_reg < 5'(pfc_pkg::CELLS));
        fin_ok = (k_reg != pfc_pkg::IDX_J) && !used_reg[k_reg]
                 && (fill_reg < 5'(pfc_pkg::CELLS));
        pair_in_square = pfc_pkg::is_upper(pend_reg) && pfc_pkg::is_upper(c_fold)
                         && used_reg[pend_idx] && used_reg[cur_idx];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        pfc_pkg::REQ_CLEAR, pfc_pkg::REQ_KEY: state_next = pfc_pkg::ST_IDLE;
                        pfc_pkg::REQ_FINAL: begin
                            if (!sealed_reg) state_next = pfc_pkg::ST_FIN;
                        end
                        pfc_pkg::REQ_TEXT: begin
                            if (pend_valid_reg)
                                state_next = pair_in_square ? pfc_pkg::ST_POS
                                                            : pfc_pkg::ST_OUT1;
                            else if (s_tlast)
                                state_next = pfc_pkg::ST_OUT2;
                        end
                    endcase
                end
            end
            pfc_pkg::ST_FIN: begin
                if (k_reg == pfc_pkg::IDX_LAST) state_next = pfc_pkg::ST_IDLE;
            end
            pfc_pkg::ST_POS: begin
                state_next = geom.same_line ? pfc_pkg::ST_OUT1 : pfc_pkg::ST_CORNER;
            end
            pfc_pkg::ST_CORNER: state_next = pfc_pkg::ST_OUT1;
            pfc_pkg::ST_OUT1: begin
                if (m_tready) state_next = pfc_pkg::ST_OUT2;
            end
            pfc_pkg::ST_OUT2: begin
                if (m_tready) state_next = pfc_pkg::ST_IDLE;
            end
            default: state_next = pfc_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == pfc_pkg::ST_IDLE);
        m_tvalid = (state_reg == pfc_pkg::ST_OUT1) || (state_reg == pfc_pkg::ST_OUT2);
        m_tdata  = (state_reg == pfc_pkg::ST_OUT1) ? o1_reg : o2_reg;
        m_tlast  = (state_reg == pfc_pkg::ST_OUT2);
    end

    // memory requests: reads are issued every cycle, data arrives the next
    always_comb begin
        mreq.we      = 1'b0;
        mreq.fill    = fill_reg;
        mreq.letter  = (state_reg == pfc_pkg::ST_FIN) ? k_reg : cur_idx;
        mreq.pos_ra0 = pend_idx;
        mreq.pos_ra1 = cur_idx;
        mreq.sq_ra0  = geom.addr0;
        mreq.sq_ra1  = geom.addr1;
        if (state_reg == pfc_pkg::ST_FIN)
            mreq.we = fin_ok;
        else if (state_reg == pfc_pkg::ST_IDLE)
            mreq.we = accept && key_ok;
    end

    // datapath
    always_comb begin
        fill_next       = fill_reg;
        used_next       = used_reg;
        sealed_next     = sealed_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        o1_next         = o1_reg;
        o2_next         = o2_reg;
        k_next          = k_reg;
        blank0_next     = blank0_reg;
        blank1_next     = blank1_reg;
        if (mreq.we) begin
            fill_next               = fill_reg + 5'd1;
            used_next[mreq.letter]  = 1'b1;
        end
        unique case (state_reg)
            pfc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        pfc_pkg::REQ_CLEAR: begin
                            fill_next       = '0;
                            used_next       = '0;
                            sealed_next     = 1'b0;
                            pend_valid_next = 1'b0;
                        end
                        pfc_pkg::REQ_KEY: ;
                        pfc_pkg::REQ_FINAL: k_next = '0;
                        pfc_pkg::REQ_TEXT: begin
                            if (pend_valid_reg) begin
                                pend_valid_next = 1'b0;
                                a_next  = pend_reg;
                                b_next  = c_fold;
                                o1_next = pend_reg;
                                o2_next = c_fold;
                            end else if (s_tlast) begin
                                o2_next = c_fold;
                            end else begin
                                pend_next       = c_fold;
                                pend_valid_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            pfc_pkg::ST_FIN: begin
                if (k_reg == pfc_pkg::IDX_LAST)
                    sealed_next = 1'b1;
                else
                    k_next = k_reg + 5'd1;
            end
            pfc_pkg::ST_POS: begin
                // same row or column: swap
                o1_next = b_reg;
                o2_next = a_reg;
                // cells past the fill count are read as letter index 0
                blank0_next = (geom.addr0 >= fill_reg);
                blank1_next = (geom.addr1 >= fill_reg);
            end
            pfc_pkg::ST_CORNER: begin
                o1_next = blank0_reg ? pfc_pkg::CHAR_UC_A
                                     : pfc_pkg::CHAR_UC_A + 8'(mrsp.sq0);
                o2_next = blank1_reg ? pfc_pkg::CHAR_UC_A
                                     : pfc_pkg::CHAR_UC_A + 8'(mrsp.sq1);
            end
            pfc_pkg::ST_OUT1, pfc_pkg::ST_OUT2: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pfc_pkg::ST_IDLE;
            fill_reg       <= '0;
            used_reg       <= '0;
            sealed_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            k_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            used_reg       <= used_next;
            sealed_reg     <= sealed_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        o1_reg     <= o1_next;
        o2_reg     <= o2_next;
        blank0_reg <= blank0_next;
        blank1_reg <= blank1_next;
    end

    `PFC_ASSERT_ALWAYS(a_fill_bound, fill_reg <= 5'(pfc_pkg::CELLS), "fill count past 25")
    `PFC_ASSERT_ALWAYS(a_no_j, !used_reg[pfc_pkg::IDX_J], "J entered the square")
    `PFC_ASSERT_ALWAYS(a_one_in_flight, !(s_tready && m_tvalid), "input taken during output")
    `PFC_ASSERT_NEXT(a_fin_full, (state_reg == pfc_pkg::ST_FIN) && (k_reg == pfc_pkg::IDX_LAST), fill_reg == 5'(pfc_pkg::CELLS) && sealed_reg, "square not full after finalize")

endmodule
